// File: hw/rtl/dtq_pkg.sv
// Package for the deadline timer queue: payload structs, command and status codes.
// Used by every module of the block; no dependencies.
package dtq_pkg;

  localparam int NumTimers = 16;
  localparam int SlotW = 4;
  localparam logic [31:0] DefaultWindow = 32'd3600000;
  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [2:0] CmdAdd     = 3'd0;
  localparam logic [2:0] CmdRefresh = 3'd1;
  localparam logic [2:0] CmdReset   = 3'd2;
  localparam logic [2:0] CmdCancel  = 3'd3;
  localparam logic [2:0] CmdPoll    = 3'd4;
  localparam logic [2:0] CmdQuery   = 3'd5;

  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StActive    = 2'd1;
  localparam logic [1:0] StNotActive = 2'd2;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  timer_slot;
    logic [31:0] interval;
    logic        recurring;
    logic        count_now;
    logic [63:0] now;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  timer_slot_res;
    logic        fired;
    logic        stepped_back;
    logic [63:0] delay;
    logic        last;
  } out_item_t;

  // Token circulated down the cell chain during a minimum search.
  typedef struct packed {
    logic             found;
    logic [SlotW-1:0] slot;
    logic [63:0]      deadline;
  } min_tok_t;

  // Commands broadcast from the controller to every cell.
  typedef struct packed {
    logic             wr;       // write cell addressed by slot
    logic [SlotW-1:0] slot;
    logic             set_act;
    logic             act;
    logic             set_rec;
    logic             rec;
    logic             set_int;
    logic [31:0]      interval;
    logic             set_dl;
    logic [63:0]      deadline;
    logic             clr_done;  // clear all done marks
    logic             fire;      // fire slot: mark done, re-arm or free
    logic [63:0]      now;
  } cell_ctl_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? AllOnes : s[63:0];
  endfunction

endpackage

// File: hw/rtl/deadline_timer_queue_top.sv
// Top level of the deadline timer queue: controller plus a chain of slot cells.
// Depends on dtq_pkg and dtq_cell.
//
// Usage: commands enter on in_valid/in_stall/in_data; results leave on
// out_valid/out_stall/out_data, one per transfer, last set on the final one.
// The user must write the step-back window through cfg_we/cfg_wdata only while
// the block is idle; the block itself does not enforce this. A slot command
// (add, refresh, reset, cancel) passes through S_SLOT, which registers its
// result. A search walks the token down the 16-cell chain, one cell per cycle,
// and ends in S_EMIT, which registers a query result. A poll runs one search
// per reported slot plus a closing one; each fired report is held until the
// next search shows whether it is last. A poll with nothing expired answers
// after its single search. The chain length sets how long a search takes.
// While a result waits under out_stall the controller holds; in_stall stays
// high until the command's last result has transferred, and the next command
// can transfer in the cycle after.
// Reset (rst, synchronous) frees every slot, clears the previous poll time
// and loads the default window of one hour.
module deadline_timer_queue_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dtq_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dtq_pkg::out_item_t   out_data,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_wdata
);

  localparam int N = dtq_pkg::NumTimers;
  localparam int CntW = $clog2(N + 2);

  typedef enum logic [2:0] {
    S_IDLE, S_SLOT, S_SEARCH, S_EMIT, S_WAIT
  } state_t;

  state_t state;
  dtq_pkg::in_item_t cur;
  logic [31:0] window;
  logic [63:0] prev_poll;
  logic sb;
  logic [CntW-1:0] cnt;
  logic held;
  logic [dtq_pkg::SlotW-1:0] held_slot;

  dtq_pkg::cell_ctl_t ctl;
  dtq_pkg::cell_ctl_t ctl_next;
  logic [1:0] slot_st;
  dtq_pkg::min_tok_t tok [0:N];
  logic [N-1:0] act_v;
  logic [31:0] int_v [0:N-1];
  logic [63:0] dl_v [0:N-1];

  assign tok[0] = '0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    dtq_cell u_cell (
      .clk(clk), .rst(rst), .idx(dtq_pkg::SlotW'(g)), .ctl(ctl), .sb(sb),
      .poll_mode(cur.cmd == dtq_pkg::CmdPoll), .tok_in(tok[g]),
      .tok_out(tok[g+1]), .active(act_v[g]),
      .interval(int_v[g]), .deadline(dl_v[g])
    );
  end

  assign in_stall = (state != S_IDLE);

  // Selected slot state for slot commands.
  logic        s_act;
  logic [31:0] s_int;
  logic [63:0] s_dl;
  logic [63:0] start;
  assign s_act = act_v[cur.timer_slot];
  assign s_int = int_v[cur.timer_slot];
  assign s_dl  = dl_v[cur.timer_slot];
  assign start = cur.count_now ? cur.now :
                 (s_dl >= {32'd0, s_int}) ? s_dl - {32'd0, s_int} : 64'd0;

  always_comb begin
    ctl_next = '0;
    ctl_next.now = cur.now;
    slot_st = dtq_pkg::StOk;
    if (cur.cmd == dtq_pkg::CmdAdd) begin
      if (s_act) slot_st = dtq_pkg::StActive;
    end else if (!s_act) begin
      slot_st = dtq_pkg::StNotActive;
    end
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl_next.now = in_data.now;
          ctl_next.clr_done = (in_data.cmd == dtq_pkg::CmdPoll);
        end
      end
      S_SLOT: begin
        ctl_next.slot = cur.timer_slot;
        if (slot_st == dtq_pkg::StOk) begin
          ctl_next.wr = 1'b1;
          case (cur.cmd)
            dtq_pkg::CmdAdd: begin
              ctl_next.set_act = 1'b1; ctl_next.act = 1'b1;
              ctl_next.set_rec = 1'b1; ctl_next.rec = cur.recurring;
              ctl_next.set_int = 1'b1; ctl_next.interval = cur.interval;
              ctl_next.set_dl = 1'b1;
              ctl_next.deadline = dtq_pkg::sat_add(cur.now, {32'd0, cur.interval});
            end
            dtq_pkg::CmdRefresh: begin
              ctl_next.set_dl = 1'b1;
              ctl_next.deadline = dtq_pkg::sat_add(cur.now, {32'd0, s_int});
            end
            dtq_pkg::CmdReset: begin
              ctl_next.set_int = 1'b1; ctl_next.interval = cur.interval;
              ctl_next.set_dl = 1'b1;
              ctl_next.deadline = dtq_pkg::sat_add(start, {32'd0, cur.interval});
            end
            default: begin
              ctl_next.set_act = 1'b1; ctl_next.act = 1'b0;
            end
          endcase
        end
      end
      S_EMIT: begin
        if (cur.cmd == dtq_pkg::CmdPoll && tok[N].found) begin
          ctl_next.fire = 1'b1;
          ctl_next.slot = tok[N].slot;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      window <= dtq_pkg::DefaultWindow;
      prev_poll <= '0;
      out_valid <= 1'b0;
      ctl <= '0;
      cnt <= '0;
      sb <= 1'b0;
      held <= 1'b0;
      held_slot <= '0;
    end else begin
      ctl <= ctl_next;
      if (cfg_we) window <= cfg_wdata;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur <= in_data;
            case (in_data.cmd)
              dtq_pkg::CmdPoll: begin
                sb <= (prev_poll > {32'd0, window}) &&
                      (in_data.now < prev_poll - {32'd0, window});
                prev_poll <= in_data.now;
                held <= 1'b0;
                cnt <= '0;
                state <= S_SEARCH;
              end
              dtq_pkg::CmdQuery: begin
                cnt <= '0;
                state <= S_SEARCH;
              end
              dtq_pkg::CmdAdd, dtq_pkg::CmdRefresh, dtq_pkg::CmdReset,
              dtq_pkg::CmdCancel: state <= S_SLOT;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SLOT: begin
          out_data <= '{status: slot_st, timer_slot_res: cur.timer_slot,
                        fired: 1'b0, stepped_back: 1'b0, delay: 64'd0, last: 1'b1};
          out_valid <= 1'b1;
          state <= S_WAIT;
        end
        S_SEARCH: begin
          // The search waits here while the token travels to the chain end after done marks settle.
          if (cnt == CntW'(N + 1)) begin
            cnt <= '0;
            state <= S_EMIT;
          end else begin
            cnt <= cnt + CntW'(1);
          end
        end
        S_EMIT: begin
          if (cur.cmd == dtq_pkg::CmdQuery) begin
            out_data <= '{status: dtq_pkg::StOk,
                          timer_slot_res: tok[N].found ? tok[N].slot : '0,
                          fired: 1'b0, stepped_back: 1'b0,
                          delay: !tok[N].found ? dtq_pkg::AllOnes :
                                 (tok[N].deadline <= cur.now) ? 64'd0 :
                                 tok[N].deadline - cur.now,
                          last: 1'b1};
            out_valid <= 1'b1;
            state <= S_WAIT;
          end else if (tok[N].found) begin
            // Fire the new slot and hold it; send the one held before, which
            // is now known not to be last.
            held <= 1'b1;
            held_slot <= tok[N].slot;
            if (held) begin
              out_data <= '{status: dtq_pkg::StOk, timer_slot_res: held_slot,
                            fired: 1'b1, stepped_back: sb, delay: 64'd0, last: 1'b0};
              out_valid <= 1'b1;
              state <= S_WAIT;
            end else begin
              state <= S_SEARCH;
            end
          end else begin
            // Nothing more: the held report is last, or nothing fired at all.
            held <= 1'b0;
            out_data <= '{status: dtq_pkg::StOk, timer_slot_res: held ? held_slot : '0,
                          fired: held, stepped_back: sb, delay: 64'd0, last: 1'b1};
            out_valid <= 1'b1;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
            state <= out_data.last ? S_IDLE : S_SEARCH;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/dtq_cell.sv
// One timer slot cell: holds slot state and passes a search token to its neighbor.
// Depends on dtq_pkg.
module dtq_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [dtq_pkg::SlotW-1:0]   idx,
  input  dtq_pkg::cell_ctl_t          ctl,
  input  logic                        sb,
  input  logic                        poll_mode,
  input  dtq_pkg::min_tok_t           tok_in,
  output dtq_pkg::min_tok_t           tok_out,
  output logic                        active,
  output logic [31:0]                 interval,
  output logic [63:0]                 deadline
);

  logic done;
  logic cand;
  logic recurring;

  // A cell competes when active and, for polls, not yet reported and either expired or stepped back.
  assign cand = active && !(poll_mode && done) &&
                (!poll_mode || sb || deadline <= ctl.now);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else if (cand && (!tok_in.found || deadline < tok_in.deadline)) begin
      tok_out <= '{found: 1'b1, slot: idx, deadline: deadline};
    end else begin
      tok_out <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      recurring <= 1'b0;
      done <= 1'b0;
    end else begin
      if (ctl.clr_done) begin
        done <= 1'b0;
      end
      if (ctl.wr && ctl.slot == idx) begin
        if (ctl.set_act) active <= ctl.act;
        if (ctl.set_rec) recurring <= ctl.rec;
        if (ctl.set_int) interval <= ctl.interval;
        if (ctl.set_dl) deadline <= ctl.deadline;
      end
      if (ctl.fire && ctl.slot == idx) begin
        done <= 1'b1;
        if (recurring) begin
          deadline <= dtq_pkg::sat_add(ctl.now, {32'd0, interval});
        end else begin
          active <= 1'b0;
        end
      end
    end
  end

endmodule

// File: hw/rtl/dtq_checker.sv
// Port-level checker for the deadline timer queue, bound to the top level.
// Depends on dtq_pkg.
module dtq_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input dtq_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status != 2'd3)
    else $error("undefined status");

  a_fired_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.fired |-> out_data.status == dtq_pkg::StOk &&
    out_data.delay == 64'd0)
    else $error("fired result with bad fields");

endmodule

bind deadline_timer_queue_top dtq_checker u_dtq_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
